/* sv/integer_square_root_assert.svh */
// Assertion macros shared by the integer square root RTL.
`ifndef INTEGER_SQUARE_ROOT_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("isr assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ISR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("isr assertion failed: next-cycle check");

`endif

/* sv/isr_pkg.sv */
package isr_pkg;

  // Microprogram step address
  typedef logic [1:0] step_t;

  localparam step_t StepLoad = 2'd0;
  localparam step_t StepIter = 2'd1;
  localparam step_t StepEmit = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_ITER,
    OP_EMIT
  } op_e;

  // Jump condition; jump taken when the condition holds
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_IDLE,
    COND_MORE,
    COND_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jmp;
    step_t nxt;
  } ucode_t;

  // Datapath control from the sequencer
  typedef struct packed {
    logic load;
    logic iter;
  } dp_ctrl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic more;
  } dp_stat_t;

  // Control store
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      StepLoad: w = '{op: OP_LOAD, cond: COND_IN_IDLE,  jmp: StepLoad, nxt: StepIter};
      StepIter: w = '{op: OP_ITER, cond: COND_MORE,     jmp: StepIter, nxt: StepEmit};
      StepEmit: w = '{op: OP_EMIT, cond: COND_OUT_FULL, jmp: StepEmit, nxt: StepLoad};
      default:  w = '{op: OP_NOP,  cond: COND_ALWAYS,   jmp: StepLoad, nxt: StepLoad};
    endcase
    return w;
  endfunction

endpackage

/* sv/isr_datapath.sv */
// One root bit per iteration: shift in two radicand bits, trial subtract.
module isr_datapath #(
  parameter int IN_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  isr_pkg::dp_ctrl_t           ctrl_i,
  input  logic [IN_WIDTH-1:0]         radicand_i,
  output isr_pkg::dp_stat_t           stat_o,
  output logic [(IN_WIDTH+1)/2-1:0]   root_o
);

  localparam int RW = (IN_WIDTH + 1) / 2;
  localparam int XW = 2 * RW;
  localparam int CW = $clog2(RW + 1);

  logic [XW-1:0] x_q,    x_d;
  logic [RW+1:0] rem_q,  rem_d;
  logic [RW-1:0] root_q, root_d;
  logic [CW-1:0] cnt_q,  cnt_d;

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic [RW+2:0] diff;

  // Remainder stays below 2^RW before every shift, so the top two bits drop safely
  assign rem_sh = {rem_q[RW-1:0], x_q[XW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (ctrl_i.load) begin
      x_d    = XW'(radicand_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(RW - 1);
    end else if (ctrl_i.iter) begin
      x_d   = x_q << 2;
      cnt_d = cnt_q - CW'(1);
      if (diff[RW+2]) begin
        rem_d  = rem_sh;
        root_d = RW'({root_q, 1'b0});
      end else begin
        rem_d  = diff[RW+1:0];
        root_d = RW'({root_q, 1'b1});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.more = (cnt_q != '0);
  assign root_o      = root_q;

endmodule

/* sv/integer_square_root.sv */
// Channel | Handshake                  | Payload
// --------+----------------------------+---------------------------
// in      | in_valid_i / in_ready_o    | radicand_i [IN_WIDTH-1:0]
// out     | out_valid_o / out_ready_i  | root_o [15:0]
//
// Steps: a load step, (IN_WIDTH+1)/2 iteration steps and an emit step per request;
//   the bit-per-step remainder loop yields one root bit per iteration step.
// Reset: rst_ni clears the step counter, the iteration count and the output valid.
// Stalls: the result sits in an output register; the emit step waits only when
//   that register still holds an untaken result.
// in_ready_o is high during the load step.
`include "integer_square_root_assert.svh"

module integer_square_root #(
  parameter int IN_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [IN_WIDTH-1:0] radicand_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         root_o
);

  localparam int RW = (IN_WIDTH + 1) / 2;

  // Sequencer
  isr_pkg::step_t    pc_q, pc_d;
  isr_pkg::ucode_t   uw;
  isr_pkg::dp_ctrl_t dp_ctrl;
  isr_pkg::dp_stat_t dp_stat;
  logic              cond_hit;
  logic              out_full;
  logic              out_take;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [15:0]       root_q;

  logic [RW-1:0]     dp_root;
  logic [RW+15:0]    root_ext;

  assign uw       = isr_pkg::ucode_rom(pc_q);
  assign out_full = out_valid_q && !out_ready_i;

  always_comb begin
    case (uw.cond)
      isr_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      isr_pkg::COND_IN_IDLE:  cond_hit = !in_valid_i;
      isr_pkg::COND_MORE:     cond_hit = dp_stat.more;
      isr_pkg::COND_OUT_FULL: cond_hit = out_full;
      default:                cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? uw.jmp : uw.nxt;
  end

  assign in_ready_o   = (uw.op == isr_pkg::OP_LOAD);
  assign dp_ctrl.load = in_ready_o && in_valid_i;
  assign dp_ctrl.iter = (uw.op == isr_pkg::OP_ITER);
  assign out_take     = (uw.op == isr_pkg::OP_EMIT) && !out_full;
  assign out_valid_d  = out_take || out_full;

  // Root truncated or zero-extended to the 16-bit field
  assign root_ext = {16'b0, dp_root};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= isr_pkg::StepLoad;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      root_q <= root_ext[15:0];
    end
  end

  isr_datapath #(
    .IN_WIDTH (IN_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dp_ctrl),
    .radicand_i (radicand_i),
    .stat_o     (dp_stat),
    .root_o     (dp_root)
  );

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;

  // Accepted request always starts the iteration
  `ISR_ASSERT_NEXT(a_load_to_iter, clk_i, rst_ni, dp_ctrl.load, pc_q == isr_pkg::StepIter)
  // Last iteration hands over to the emit step
  `ISR_ASSERT_NEXT(a_iter_to_emit, clk_i, rst_ni, dp_ctrl.iter && !dp_stat.more,
                   pc_q == isr_pkg::StepEmit)
  // A result written into the output register is offered next cycle
  `ISR_ASSERT_NEXT(a_take_valid, clk_i, rst_ni, out_take, out_valid_o)
  // No request is taken while the iteration runs
  `ISR_ASSERT_NOW(a_no_ready_busy, clk_i, rst_ni, pc_q != isr_pkg::StepLoad, !in_ready_o)

endmodule

/* sim/integer_square_root_checker.sv */
`timescale 1ns / 100ps

// Watches both channels, predicts the floor root of each accepted radicand
// and compares it with the roots the block returns, in order.
module integer_square_root_checker #(
  parameter int IN_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [IN_WIDTH-1:0] radicand_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [15:0]         root_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         roots_pending_o
);

  typedef struct packed {
    logic [IN_WIDTH-1:0] radicand;
    logic [15:0]         root;
  } root_entry_t;

  root_entry_t awaited_roots[$];

  // Newton iteration from half the radicand; stops once a step no longer
  // lowers the guess.
  function automatic logic [15:0] floor_sqrt(input logic [IN_WIDTH-1:0] n);
    logic [63:0] value;
    logic [63:0] guess;
    logic [63:0] next_guess;
    bit          done;
    value = 64'(n);
    if (value < 64'd2) return value[15:0];
    guess = value >> 1;
    done  = 1'b0;
    while (!done) begin
      next_guess = (guess + value / guess) >> 1;
      if (next_guess >= guess) done = 1'b1;
      else guess = next_guess;
    end
    return guess[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    root_entry_t oldest;
    if (!rst_ni) begin
      awaited_roots.delete();
      mismatch_count_o = 0;
      roots_pending_o  = 0;
    end else begin
      // a root can never leave in the cycle its radicand arrives
      if (out_valid_i && out_ready_i) begin
        if (awaited_roots.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected root: expected none, actual %0d", $time, root_i);
        end else begin
          oldest = awaited_roots.pop_front();
          if (root_i !== oldest.root) begin
            mismatch_count_o++;
            $display("%0t: root of %0d: expected %0d, actual %0d",
                     $time, oldest.radicand, oldest.root, root_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_roots.push_back('{radicand: radicand_i, root: floor_sqrt(radicand_i)});
      end
      roots_pending_o = awaited_roots.size();
    end
  end

endmodule

/* sim/tb_integer_square_root.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the integer square root block. The checker beside
// the block does all prediction and comparison.
module tb_integer_square_root;

  localparam int IN_WIDTH     = 32;
  localparam int RANDOM_COUNT = 850;
  // last requests run with no idling on either side
  localparam int STEADY_COUNT = 120;
  // cycles with no handshake on either channel before giving up; a correct
  // request needs its load, iteration and emit steps plus an idle gap on each side
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [IN_WIDTH-1:0] radicand;
  logic                out_valid;
  logic                out_ready;
  logic [15:0]         root;

  int unsigned mismatch_count;
  int unsigned roots_pending;

  bit          idle_enable;
  int unsigned ready_hold;
  int unsigned quiet_cycles;

  integer_square_root #(
    .IN_WIDTH(IN_WIDTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .radicand_i (radicand),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .root_o     (root)
  );

  integer_square_root_checker #(
    .IN_WIDTH(IN_WIDTH)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .radicand_i      (radicand),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .root_i          (root),
    .mismatch_count_o(mismatch_count),
    .roots_pending_o (roots_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result side: ready drops low at random while idling is on,
  // otherwise holds high for random stretches.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_enable && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 14);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 20);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("integer_square_root test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request, maybe after a random gap, and returns once it is
  // taken. Valid stays high across back-to-back requests.
  task automatic send_radicand(input logic [IN_WIDTH-1:0] value);
    int unsigned gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    radicand <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the request channel quiet until every root has come back.
  task automatic drain_roots();
    in_valid <= 1'b0;
    @(posedge clk);
    while (roots_pending != 0) @(posedge clk);
  endtask

  // Mix of shapes: full range, random bit lengths, perfect squares and their
  // neighbors, tiny values, values near the top.
  function automatic logic [IN_WIDTH-1:0] random_radicand();
    logic [31:0] side;
    logic [31:0] value;
    side = $urandom_range(0, 65535);
    case ($urandom_range(0, 5))
      0, 1:    value = $urandom;
      2:       value = $urandom >> $urandom_range(0, 31);
      3:       value = side * side + 32'($urandom_range(0, 2)) - 32'd1;
      4:       value = $urandom_range(0, 300);
      default: value = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
    endcase
    return value;
  endfunction

  logic [IN_WIDTH-1:0] directed_values[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd15, 32'd16,
    32'd24, 32'd25, 32'hFFFF_FFFF, 32'hFFFE_0001, 32'hFFFE_0000, 32'hFFFE_0002,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'd1, 32'd0
  };

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    radicand    <= '0;
    idle_enable  = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edges of the field, zero and one, perfect squares and neighbors
    foreach (directed_values[i]) send_radicand(directed_values[i]);
    drain_roots();

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == RANDOM_COUNT - STEADY_COUNT) idle_enable = 1'b0;
      if (i == RANDOM_COUNT / 2) drain_roots();
      send_radicand(random_radicand());
    end
    in_valid <= 1'b0;

    while (roots_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && roots_pending == 0) begin
      $display("integer_square_root test passed");
    end else begin
      $display("integer_square_root test failed");
    end
    $finish;
  end

endmodule
